### rtl/core/clocked_multimode_step_generator_unit_defines.svh
// Assertion macros for the step generator checker.
`ifndef CLOCKED_MULTIMODE_STEP_GENERATOR_UNIT_DEFINES_SVH
`define CLOCKED_MULTIMODE_STEP_GENERATOR_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define CMSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CMSG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cmsg_pkg.sv
// Shared constants, codes and helper functions for the step generator.
package cmsg_pkg;

    localparam int INDEX_DEPTH  = 64;
    localparam int PATTERN_BITS = 16;
    localparam int NUM_VOICES   = 6;
    localparam int WORD_W       = 6;
    localparam int MODE_W       = 4;
    localparam int BEAT_LEN_W   = 5;
    localparam int OP_W         = 2;
    localparam int LFSR_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = (PATTERN_BITS > BEAT_LEN_W) ? PATTERN_BITS : BEAT_LEN_W;
    localparam int TDATA_W      = 8;

    localparam logic [WORD_W-1:0] COUNT_TOP  = WORD_W'((INDEX_DEPTH - 1) & 63);
    localparam logic [WORD_W-1:0] SINE_TOP   = 6'd15;
    localparam logic [WORD_W-1:0] TOP_RESET  = 6'd63;
    localparam logic [LFSR_W-1:0] SEED_BITS  = 16'h8800;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h8000;
    localparam logic [BEAT_LEN_W-1:0] BEAT_LEN_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_CLOCK  = 2'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PASS      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_UP        = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DOWN      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BOUNCE    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_NOISE     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LOCKED    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SINE      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DIV       = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SINE_DIV  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_RHYTHM    = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN0    = 3'd2;

    function automatic logic [WORD_W-1:0] sine_lookup(input logic [3:0] idx);
        logic [WORD_W-1:0] s;
        case (idx)
            4'd0:    s = 6'd32;
            4'd1:    s = 6'd44;
            4'd2:    s = 6'd54;
            4'd3:    s = 6'd61;
            4'd4:    s = 6'd63;
            4'd5:    s = 6'd61;
            4'd6:    s = 6'd54;
            4'd7:    s = 6'd44;
            4'd8:    s = 6'd32;
            4'd9:    s = 6'd19;
            4'd10:   s = 6'd9;
            4'd11:   s = 6'd2;
            4'd12:   s = 6'd0;
            4'd13:   s = 6'd2;
            4'd14:   s = 6'd9;
            default: s = 6'd19;
        endcase
        return s;
    endfunction

    function automatic logic [PATTERN_BITS-1:0] beat_reload(input logic [BEAT_LEN_W-1:0] len);
        logic [BEAT_LEN_W-1:0] n;
        n = len;
        if (n == '0)
            n = BEAT_LEN_W'(1);
        if (n > BEAT_LEN_W'(PATTERN_BITS))
            n = BEAT_LEN_W'(PATTERN_BITS);
        return PATTERN_BITS'(1) << (n - BEAT_LEN_W'(1));
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] w);
        logic fb;
        fb = w[12] ^ w[7] ^ w[4] ^ w[1];
        return {fb, w[LFSR_W-1:1]};
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_rotate(input logic [LFSR_W-1:0] w);
        return {w[0], w[LFSR_W-1:1]};
    endfunction

endpackage

### rtl/core/clocked_multimode_step_generator_unit.sv
// Eleven-mode clock-edge step generator: input register, mode update, result register.
// Each beat moves from input register to result register; m_tvalid rises if it yields a result.
// Throughput: one input beat per cycle unless the result register stalls; the state update is a
//   single pass between the input and result registers, and a result stall only stalls input.
// Reset (rst_n low, async): mode 0, beat_length 16, patterns clear, generator state to its
//   power-up values, both pipeline stages empty.
module clocked_multimode_step_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [cmsg_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cmsg_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmsg_pkg::TDATA_W-1:0]    s_tdata,   // [5:0] control_sample, [7:6] zero
    input  logic [cmsg_pkg::OP_W-1:0]       s_tuser,   // [1:0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cmsg_pkg::TDATA_W-1:0]    m_tdata    // [5:0] out_value, [7:6] zero
);
    import cmsg_pkg::*;

    logic                    in_valid_reg;
    logic [OP_W-1:0]         in_op_reg;
    logic [WORD_W-1:0]       in_sample_reg;
    logic                    out_valid_reg;
    logic [WORD_W-1:0]       out_value_reg;

    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [BEAT_LEN_W-1:0]   beat_len_reg, beat_len_next;
    logic [PATTERN_BITS-1:0] pattern_reg [NUM_VOICES];
    logic [PATTERN_BITS-1:0] pattern_next [NUM_VOICES];
    logic [WORD_W-1:0]       position_reg, position_next;
    logic                    count_up_reg, count_up_next;
    logic                    frozen_reg, frozen_next;
    logic [LFSR_W-1:0]       lfsr_reg, lfsr_next;
    logic [WORD_W-1:0]       div_count_reg, div_count_next;
    logic [WORD_W-1:0]       top_reg, top_next;
    logic [PATTERN_BITS-1:0] beat_reg, beat_next;
    logic [WORD_W-1:0]       last_reg, last_next;

    logic                    advance;
    logic                    res_valid;
    logic [WORD_W-1:0]       res_value;
    logic [7:0]              idx8;
    logic [7:0]              top8;
    logic [WORD_W:0]         idx7;
    logic [WORD_W-1:0]       bits;
    logic [WORD_W-1:0]       v;
    logic [CFG_IDX_W-1:0]    pat_sel;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_value_reg);
    assign pat_sel  = wr_index - REG_PATTERN0;

    always_comb
    begin
        mode_next      = mode_reg;
        beat_len_next  = beat_len_reg;
        pattern_next   = pattern_reg;
        position_next  = position_reg;
        count_up_next  = count_up_reg;
        frozen_next    = frozen_reg;
        lfsr_next      = lfsr_reg;
        div_count_next = div_count_reg;
        top_next       = top_reg;
        beat_next      = beat_reg;
        last_next      = last_reg;
        res_valid      = 1'b0;
        res_value      = '0;
        idx8           = '0;
        top8           = '0;
        idx7           = '0;
        bits           = '0;
        v              = '0;

        if (advance)
        begin
            if (in_op_reg == OP_TOGGLE)
            begin
                count_up_next = ~count_up_next;
                frozen_next   = ~frozen_next;
            end
            else if (in_op_reg == OP_RESET)
            begin
                if (mode_reg < MODE_RHYTHM)
                    position_next = count_up_next ? '0 : top_reg;
                else
                    beat_next = beat_reload(beat_len_reg);
            end

            if (mode_reg == MODE_PASS)
            begin
                if (in_sample_reg != last_reg)
                begin
                    last_next = in_sample_reg;
                    res_valid = 1'b1;
                    res_value = in_sample_reg;
                end
            end
            else if (in_op_reg == OP_CLOCK)
            begin
                if (mode_reg >= MODE_RHYTHM)
                begin
                    for (int k = 0; k < NUM_VOICES; k++)
                        bits[NUM_VOICES-1-k] = |(pattern_reg[k] & beat_next);
                    beat_next = beat_next >> 1;
                    if (beat_next == '0)
                        beat_next = beat_reload(beat_len_reg);
                    last_next = bits ^ in_sample_reg;
                    res_valid = 1'b1;
                    res_value = bits ^ in_sample_reg;
                end
                else
                begin
                    case (mode_reg)
                        MODE_SAMPLE:
                            position_next = in_sample_reg;
                        MODE_UP, MODE_DOWN, MODE_SINE:
                        begin
                            idx8 = count_up_next ? 8'(position_reg) + 8'd1
                                                 : 8'(position_reg) - 8'd1;
                            top8 = 8'(top_reg) + 8'd1;
                            if (idx8 == top8)
                                idx8 = '0;
                            else if (idx8 > top8)
                                idx8 = 8'(top_reg);
                            position_next = idx8[WORD_W-1:0];
                        end
                        MODE_BOUNCE:
                        begin
                            if (!count_up_next && position_reg == '0)
                                count_up_next = 1'b1;
                            else
                            begin
                                idx7 = count_up_next ? {1'b0, position_reg} + 7'd1
                                                     : {1'b0, position_reg} - 7'd1;
                                if (idx7 >= {1'b0, top_reg})
                                begin
                                    count_up_next = 1'b0;
                                    if (idx7 > {1'b0, top_reg})
                                        idx7 = {1'b0, top_reg};
                                end
                                else if (idx7 == '0)
                                    count_up_next = 1'b1;
                                position_next = idx7[WORD_W-1:0];
                            end
                        end
                        MODE_NOISE:
                        begin
                            lfsr_next = frozen_next ? lfsr_rotate(lfsr_reg)
                                                    : lfsr_advance(lfsr_reg);
                            position_next = lfsr_next[WORD_W-1:0];
                        end
                        MODE_LOCKED:
                        begin
                            if (frozen_next)
                                lfsr_next = lfsr_rotate(lfsr_reg);
                            else
                            begin
                                lfsr_next   = lfsr_advance(lfsr_advance(lfsr_reg));
                                frozen_next = 1'b1;
                            end
                            position_next = lfsr_next[WORD_W-1:0];
                        end
                        default:
                        begin
                            if (div_count_reg >= in_sample_reg)
                            begin
                                div_count_next = '0;
                                idx7 = {1'b0, position_reg} + 7'd1;
                                position_next = (idx7 > {1'b0, top_reg}) ? '0
                                                                         : idx7[WORD_W-1:0];
                            end
                            else
                                div_count_next = div_count_reg + 6'd1;
                        end
                    endcase

                    v = position_next;
                    if ((mode_reg == MODE_SINE || mode_reg == MODE_SINE_DIV) && v < 6'd16)
                        v = sine_lookup(v[3:0]);
                    if (mode_reg >= MODE_UP && mode_reg <= MODE_SINE)
                        v = v ^ in_sample_reg;
                    if (v != last_reg)
                    begin
                        last_next = v;
                        res_valid = 1'b1;
                        res_value = v;
                    end
                end
            end
        end

        // The user must issue register writes only while the pipeline is empty; the block does not enforce it.
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MODE:
                begin
                    mode_next = wr_data[MODE_W-1:0];
                    case (mode_next)
                        MODE_UP, MODE_BOUNCE:
                        begin
                            count_up_next = 1'b1;
                            top_next      = COUNT_TOP;
                        end
                        MODE_DOWN:
                        begin
                            count_up_next = 1'b0;
                            top_next      = COUNT_TOP;
                        end
                        MODE_NOISE:
                        begin
                            count_up_next = 1'b1;
                            position_next = '0;
                            frozen_next   = 1'b0;
                            lfsr_next     = lfsr_reg | SEED_BITS;
                        end
                        MODE_LOCKED:
                        begin
                            position_next = '0;
                            frozen_next   = 1'b0;
                            lfsr_next     = lfsr_reg | SEED_BITS;
                        end
                        MODE_SINE:
                        begin
                            count_up_next = 1'b1;
                            top_next      = SINE_TOP;
                        end
                        MODE_DIV, MODE_SINE_DIV:
                            top_next = SINE_TOP;
                        default:
                        begin
                            if (mode_next >= MODE_RHYTHM)
                                beat_next = beat_reload(beat_len_reg);
                        end
                    endcase
                end
                REG_BEAT_LENGTH:
                    beat_len_next = wr_data[BEAT_LEN_W-1:0];
                default:
                    pattern_next[pat_sel] = wr_data[PATTERN_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_PASS;
            beat_len_reg  <= BEAT_LEN_RESET;
            for (int k = 0; k < NUM_VOICES; k++)
                pattern_reg[k] <= '0;
            position_reg  <= '0;
            count_up_reg  <= 1'b1;
            frozen_reg    <= 1'b0;
            lfsr_reg      <= LFSR_RESET;
            div_count_reg <= '0;
            top_reg       <= TOP_RESET;
            beat_reg      <= beat_reload(BEAT_LEN_RESET);
            last_reg      <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= res_valid;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            mode_reg      <= mode_next;
            beat_len_reg  <= beat_len_next;
            pattern_reg   <= pattern_next;
            position_reg  <= position_next;
            count_up_reg  <= count_up_next;
            frozen_reg    <= frozen_next;
            lfsr_reg      <= lfsr_next;
            div_count_reg <= div_count_next;
            top_reg       <= top_next;
            beat_reg      <= beat_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg     <= s_tuser;
            in_sample_reg <= s_tdata[WORD_W-1:0];
        end
        if (advance && res_valid)
            out_value_reg <= res_value;
    end

endmodule

### rtl/core/cmsg_checker.sv
// Port-level checker for the step generator, bound to the top level.
`include "clocked_multimode_step_generator_unit_defines.svh"

module cmsg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cmsg_pkg::TDATA_W-1:0]    m_tdata
);

    `CMSG_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !m_tvalid, "result beat during reset")
    `CMSG_ASSERT(a_out_after_in, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result beat without input two cycles before")
    `CMSG_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `CMSG_ASSERT(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "result data changed while stalled")

endmodule

bind clocked_multimode_step_generator_unit cmsg_checker u_cmsg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
